/* hdl/clwo_pkg.sv */
// clwo_pkg: constants, register indexes and helpers for the wheel odometry block
// used by car_like_wheel_odometry; no dependencies
`default_nettype none
package clwo_pkg;

   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DIST_PER_TICK = 3'd0,
      CSR_ANGLE_PER_CNT = 3'd1,
      CSR_TRACK_WIDTH   = 3'd2,
      CSR_WHEELBASE     = 3'd3,
      CSR_IMU_MODE      = 3'd4
   } csr_idx_type;

   localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
   localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
   localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

   // arctan(2^-i) in Q30
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'h3243F6A8;
         5'd1:  r = 30'h1DAC6705;
         5'd2:  r = 30'h0FADBAFC;
         5'd3:  r = 30'h07F56EA6;
         5'd4:  r = 30'h03FEAB76;
         5'd5:  r = 30'h01FFD55B;
         5'd6:  r = 30'h00FFFAAA;
         5'd7:  r = 30'h007FFF55;
         5'd8:  r = 30'h003FFFEA;
         5'd9:  r = 30'h001FFFFD;
         5'd10: r = 30'h000FFFFF;
         5'd11: r = 30'h0007FFFF;
         5'd12: r = 30'h0003FFFF;
         5'd13: r = 30'h0001FFFF;
         5'd14: r = 30'h0000FFFF;
         5'd15: r = 30'h00007FFF;
         5'd16: r = 30'h00003FFF;
         5'd17: r = 30'h00001FFF;
         5'd18: r = 30'h00000FFF;
         5'd19: r = 30'h000007FF;
         5'd20: r = 30'h000003FF;
         5'd21: r = 30'h000001FF;
         5'd22: r = 30'h000000FF;
         5'd23: r = 30'h0000007F;
         5'd24: r = 30'h0000003F;
         5'd25: r = 30'h0000001F;
         5'd26: r = 30'h0000000F;
         5'd27: r = 30'h00000008;
         5'd28: r = 30'h00000004;
         5'd29: r = 30'h00000002;
         5'd30: r = 30'h00000001;
         default: r = 30'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -65'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [64:0] v);
      logic signed [15:0] r;
      if (v > 65'sd32767) r = 16'sh7FFF;
      else if (v < -65'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   // magnitude of a value known to stay within 32 unsigned bits
   function automatic logic [31:0] mag32(input logic signed [34:0] v);
      logic signed [34:0] a;
      a = v[34] ? -v : v;
      return a[31:0];
   endfunction

endpackage
`default_nettype wire

/* hdl/car_like_wheel_odometry.sv */
// car_like_wheel_odometry: bicycle model odometry, serial multiplier, serial divider
// and iterative cordic under one sequencer; depends on clwo_pkg
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata  64 bits
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata 128 bits
//  csr     | in  | csr_wen              | csr_index 3, csr_wdata 24
//
// one word at a time: the shift-add multiplier forms each product bit by bit and the
// restoring divider each quotient; an item runs the front and steering products, the
// cordic and rear product when steering is nonzero, the center product, and, in model mode
// with nonzero steering, the numerator product and two divisions unless cosine or wheelbase is zero.
// reset is synchronous, clears sequencer, valid flag and last heading change and loads the csr defaults.
// a finished word waits in the output register while the next word is taken.
`default_nettype none
module car_like_wheel_odometry #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // wheel_ticks, steer_counts, current_yaw, reference_yaw
   input  wire logic [63:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // front_distance, steer_angle, rear_distance, center_distance, heading_change
   output logic [127:0]      rsp_tdata,
   input  wire logic         csr_wen,
   input  wire logic [clwo_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [23:0]  csr_wdata
);
   import clwo_pkg::*;

   localparam logic [5:0] LastStep = 6'(CORDIC_STEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_FRONT, S_PHI, S_CORD, S_REAR, S_CTR, S_NUM, S_DIV1, S_DIV2, S_DONE
   } state_type;

   state_type state_ff;

   logic [23:0] dpt_ff, apc_ff, track_ff, wb_ff;
   logic        imu_ff;

   logic signed [15:0] steer_ff, yaw_ff, ryaw_ff;
   logic signed [31:0] front_ff, rear_ff, center_ff;
   logic signed [15:0] phi_ff, hc_ff, lhc_ff;
   logic signed [33:0] x_ff, y_ff, s_ff;
   logic signed [34:0] z_ff;
   logic [30:0] c_ff;
   logic [5:0]  cnt_ff;

   logic [31:0] mcand_ff;
   logic [63:0] prod_ff, prod_in;
   logic        neg_ff;
   logic [31:0] rem_ff, rem_in, dvs_ff;
   logic [63:0] quo_ff, quo_in;

   logic        rsp_valid_ff;
   logic [127:0] rsp_data_ff;

   logic [32:0] mul_sum;
   logic signed [64:0] prod_sn;
   logic [32:0] trial;
   logic        ge;
   logic signed [33:0] xs, ys, x_in, y_in;
   logic signed [34:0] z_in, z0, z_fold, at;
   logic signed [15:0] phi_new;
   logic signed [31:0] center_new;
   logic [30:0] c_new;
   logic [63:0] q_clamp;

   always_comb begin
      // one multiplier bit per cycle
      mul_sum = {1'b0, prod_ff[63:32]} + (prod_ff[0] ? {1'b0, mcand_ff} : 33'd0);
      prod_in = {mul_sum, prod_ff[31:1]};
      prod_sn = neg_ff ? -$signed({1'b0, prod_in}) : $signed({1'b0, prod_in});
      // one quotient bit per cycle
      trial   = {rem_ff, quo_ff[63]};
      ge      = trial >= {1'b0, dvs_ff};
      rem_in  = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
      quo_in  = {quo_ff[62:0], ge};
      // cordic rotation
      xs = x_ff >>> cnt_ff[4:0];
      ys = y_ff >>> cnt_ff[4:0];
      at = $signed({5'b0, atan_q30(cnt_ff[4:0])});
      if (!z_ff[34]) begin
         x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
      end else begin
         x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
      end
      if (x_in < 0) c_new = 31'd0;
      else if (x_in > Q30_ONE) c_new = 31'(Q30_ONE);
      else c_new = x_in[30:0];
      phi_new = sat16(prod_sn >>> 11);
      z0 = {{2{phi_new[15]}}, phi_new, 17'b0};
      if (z0 > Q30_HALF_PI) z_fold = z0 - Q30_PI;
      else if (z0 < -Q30_HALF_PI) z_fold = z0 + Q30_PI;
      else z_fold = z0;
      center_new = sat32(65'(rear_ff) - (prod_sn >>> 14));
      q_clamp = (quo_in > 64'h0000_8000_0000_0000) ? 64'h0000_8000_0000_0000 : quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lhc_ff       <= '0;
         dpt_ff       <= 24'd65536;
         apc_ff       <= 24'd16384;
         track_ff     <= 24'd65536;
         wb_ff        <= 24'd163840;
         imu_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_idx_type'(csr_index))
               CSR_DIST_PER_TICK: dpt_ff   <= csr_wdata;
               CSR_ANGLE_PER_CNT: apc_ff   <= csr_wdata;
               CSR_TRACK_WIDTH:   track_ff <= csr_wdata;
               CSR_WHEELBASE:     wb_ff    <= csr_wdata;
               CSR_IMU_MODE:      imu_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  steer_ff <= req_tdata[31:16];
                  yaw_ff   <= req_tdata[47:32];
                  ryaw_ff  <= req_tdata[63:48];
                  mcand_ff <= mag32(35'($signed(req_tdata[15:0])));
                  prod_ff  <= {40'b0, dpt_ff};
                  neg_ff   <= req_tdata[15];
                  cnt_ff   <= '0;
                  state_ff <= S_FRONT;
               end
            end
            S_FRONT: begin
               prod_ff <= prod_in;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  front_ff <= sat32(prod_sn >>> 8);
                  mcand_ff <= mag32(35'(steer_ff));
                  prod_ff  <= {40'b0, apc_ff};
                  neg_ff   <= steer_ff[15];
                  cnt_ff   <= '0;
                  state_ff <= S_PHI;
               end
            end
            S_PHI: begin
               prod_ff <= prod_in;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  phi_ff <= phi_new;
                  cnt_ff <= '0;
                  if (phi_new == 16'sd0) begin
                     rear_ff  <= front_ff;
                     mcand_ff <= {8'b0, track_ff};
                     prod_ff  <= {32'b0, mag32(35'(lhc_ff))};
                     neg_ff   <= lhc_ff[15];
                     state_ff <= S_CTR;
                  end else begin
                     x_ff     <= CORDIC_X0;
                     y_ff     <= '0;
                     z_ff     <= z_fold;
                     state_ff <= S_CORD;
                  end
               end
            end
            S_CORD: begin
               x_ff   <= x_in;
               y_ff   <= y_in;
               z_ff   <= z_in;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == LastStep) begin
                  c_ff     <= c_new;
                  s_ff     <= y_in;
                  mcand_ff <= mag32(35'(front_ff));
                  prod_ff  <= {33'b0, c_new};
                  neg_ff   <= front_ff[31];
                  cnt_ff   <= '0;
                  state_ff <= S_REAR;
               end
            end
            S_REAR: begin
               prod_ff <= prod_in;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  rear_ff  <= sat32(prod_sn >>> 30);
                  mcand_ff <= {8'b0, track_ff};
                  prod_ff  <= {32'b0, mag32(35'(lhc_ff))};
                  neg_ff   <= lhc_ff[15];
                  cnt_ff   <= '0;
                  state_ff <= S_CTR;
               end
            end
            S_CTR: begin
               prod_ff <= prod_in;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  center_ff <= center_new;
                  cnt_ff    <= '0;
                  if (imu_ff) begin
                     hc_ff    <= sat16(65'(yaw_ff) - 65'(ryaw_ff));
                     state_ff <= S_DONE;
                  end else if (phi_ff == 16'sd0) begin
                     hc_ff    <= '0;
                     state_ff <= S_DONE;
                  end else begin
                     mcand_ff <= mag32(35'(center_new));
                     prod_ff  <= {32'b0, mag32(35'(s_ff))};
                     neg_ff   <= center_new[31] ^ s_ff[33];
                     state_ff <= S_NUM;
                  end
               end
            end
            S_NUM: begin
               prod_ff <= prod_in;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  cnt_ff <= '0;
                  if (c_ff == 31'd0 || wb_ff == 24'd0) begin
                     // degenerate divisor: saturate toward the sign of the numerator
                     if (prod_in == 64'd0) hc_ff <= '0;
                     else hc_ff <= neg_ff ? 16'sh8000 : 16'sh7FFF;
                     state_ff <= S_DONE;
                  end else begin
                     quo_ff   <= prod_in;
                     rem_ff   <= '0;
                     dvs_ff   <= {1'b0, c_ff};
                     state_ff <= S_DIV1;
                  end
               end
            end
            S_DIV1: begin
               quo_ff <= quo_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  quo_ff   <= {q_clamp[50:0], 13'b0};
                  rem_ff   <= '0;
                  dvs_ff   <= {8'b0, wb_ff};
                  cnt_ff   <= '0;
                  state_ff <= S_DIV2;
               end
            end
            S_DIV2: begin
               quo_ff <= quo_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  cnt_ff <= '0;
                  if (neg_ff) hc_ff <= (quo_in >= 64'd32768) ? 16'sh8000 : -$signed(quo_in[15:0]);
                  else hc_ff <= (quo_in > 64'd32767) ? 16'sh7FFF : $signed(quo_in[15:0]);
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {hc_ff, center_ff, rear_ff, phi_ff, front_ff};
                  rsp_valid_ff <= 1'b1;
                  lhc_ff       <= hc_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a taken word keeps the input closed while it is worked on
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // straight steering leaves rear travel equal to front travel
   a_straight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47:32] == 16'd0 |-> rsp_tdata[79:48] == rsp_tdata[31:0])
      else $error("rear differs from front at zero steering");

   // a new result only appears when the sequencer finishes
   a_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DONE))
      else $error("result without finished item");

endmodule
`default_nettype wire
